@@ rtl/swm_pkg.sv @@
// Shared types and constants for the star wildcard matcher.
// No dependencies; every other file in rtl/ imports this package.
package swm_pkg;

    // Character and pattern storage geometry.
    localparam int CHAR_W          = 8;
    localparam int WORD_W          = 64;
    localparam int NUM_WORDS       = 4;
    localparam int PAT_CHARS       = 32;
    localparam int PAT_BITS        = PAT_CHARS * CHAR_W;
    localparam int PTR_W           = 6;
    localparam int MAX_PATTERN_DEF = 32;

    // The wildcard character.
    localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd4;

    // Position of the current fragment after skipping leading stars.
    typedef struct packed {
        logic [PTR_W-1:0] start;
        logic [PTR_W-1:0] stop;
        logic [PTR_W-1:0] flen;
        logic             anchored;
        logic             done;
        logic             last;
    } t_frag_info;

    // Update command shared by all cells of the match chain.
    typedef struct packed {
        logic load;
        logic clear;
    } t_cell_ctl;

endpackage

@@ rtl/swm_cell.sv @@
// One cell of the shift-and chain: holds one match vector bit.
// Depends on swm_pkg for the character width and the control struct.
module swm_cell
    import swm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [CHAR_W-1:0] i_pat_char,
    input  logic [CHAR_W-1:0] i_text_char,
    input  logic              i_enable,
    input  logic              i_carry,
    output logic              o_hit,
    output logic              o_bit
);

    logic r_bit;
    logic n_bit;

    // The fragment prefix ending here extends by one character when it matches.
    assign o_hit = i_carry & i_enable & (i_pat_char == i_text_char);

    always_comb begin
        if (i_ctl.clear) begin
            n_bit = 1'b0;
        end else if (i_ctl.load) begin
            n_bit = o_hit;
        end else begin
            n_bit = r_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else begin
            r_bit <= n_bit;
        end
    end

    // The stored bit is handed to the right neighbor as its carry.
    assign o_bit = r_bit;

endmodule

@@ rtl/swm_frag_find.sv @@
// Fragment locator: skips stars at the fragment start and finds the fragment end.
// Depends on swm_pkg for pointer widths and the fragment info struct.
module swm_frag_find
    import swm_pkg::*;
(
    input  logic [PAT_CHARS-1:0] i_star,
    input  logic [PTR_W-1:0]     i_len,
    input  logic [PTR_W-1:0]     i_start,
    input  logic                 i_anchored,
    input  logic                 i_done,
    output t_frag_info           o_info
);

    logic [PTR_W-1:0] lead_idx;
    logic [PTR_W-1:0] start_n;
    logic [PTR_W-1:0] tail_idx;
    logic [PTR_W-1:0] stop_n;
    logic             anchored_n;

    // First non-star character at or after the start, or the length if none.
    always_comb begin
        lead_idx = i_len;
        for (int j = PAT_CHARS - 1; j >= 0; j--) begin
            if (PTR_W'(j) >= i_start && PTR_W'(j) < i_len && !i_star[j]) begin
                lead_idx = PTR_W'(j);
            end
        end
    end

    assign start_n = (i_start >= i_len) ? i_start : lead_idx;

    // First star after the new start closes the fragment.
    always_comb begin
        tail_idx = i_len;
        for (int j = PAT_CHARS - 1; j >= 0; j--) begin
            if (PTR_W'(j) >= start_n && PTR_W'(j) < i_len && i_star[j]) begin
                tail_idx = PTR_W'(j);
            end
        end
    end

    assign stop_n     = (start_n < i_len) ? tail_idx : start_n;
    assign anchored_n = i_anchored && (start_n == i_start);

    // A trailing star after everything matched accepts the rest of the text.
    always_comb begin
        o_info.start    = start_n;
        o_info.stop     = stop_n;
        o_info.flen     = stop_n - start_n;
        o_info.anchored = anchored_n;
        o_info.done     = i_done || (start_n >= i_len && !anchored_n);
        o_info.last     = stop_n >= i_len;
    end

endmodule

@@ rtl/swm_out_skid.sv @@
// Output register with one skid entry for the verdict channel.
// Depends on swm_pkg only by convention; holds one-bit verdicts.
module swm_out_skid
    import swm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  logic i_data,
    output logic o_full,
    output logic o_valid,
    output logic o_data,
    input  logic i_stall
);

    logic r_out_valid;
    logic r_out_data;
    logic r_skid_valid;
    logic r_skid_data;
    logic out_fire;

    assign out_fire = r_out_valid && !i_stall;

    // Valid bits: the skid entry fills only while the output register is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload follows the same routing as the valid bits.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out_data <= r_skid_data;
            end
        end else if (i_push) begin
            if (!r_out_valid || out_fire) begin
                r_out_data <= i_data;
            end else begin
                r_skid_data <= i_data;
            end
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    // The skid entry is only ever occupied behind a held output.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry occupied with empty output register");

endmodule

@@ rtl/star_wildcard_matcher.sv @@
// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+-----------------------------------------
// input    | in        | i_valid / o_stall        | i_text_char, i_char_valid, i_end_of_text
// verdict  | out       | o_valid / i_stall        | o_matched
// config   | in        | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One input item is taken every cycle while o_stall is low; the whole match step,
// including a fragment hand-over and the verdict, completes in the cycle of the transfer.
// A verdict appears on o_valid the cycle after its end-of-text transfer unless o_valid
// is held; the verdict path holds two entries, so input stalls only when two verdicts wait.
// Reset is synchronous; it clears the pattern, the match chain and the verdict queue.
// Depends on swm_pkg, swm_cell, swm_frag_find and swm_out_skid.
module star_wildcard_matcher
    import swm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [CHAR_W-1:0]    i_text_char,
    input  logic                 i_char_valid,
    input  logic                 i_end_of_text,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_matched,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    logic [WORD_W-1:0]      r_word [NUM_WORDS];
    logic [PTR_W-1:0]       r_len;
    logic [PTR_W-1:0]       r_fs;
    logic                   r_anchored;
    logic                   r_failed;
    logic                   r_done;
    logic [PTR_W-1:0]       n_fs;
    logic                   n_anchored;
    logic                   n_failed;
    logic                   n_done;

    logic [PAT_BITS-1:0]    pat_all;
    logic [PAT_BITS-1:0]    pat_shift;
    logic [PAT_CHARS-1:0]   star_mask;
    logic [PTR_W-1:0]       len_eff;
    t_frag_info             frag_a;
    t_frag_info             frag_b;
    t_frag_info             post_info;
    t_cell_ctl              cell_ctl;

    logic [MAX_PATTERN-1:0] mv;
    logic [MAX_PATTERN-1:0] hit;
    logic [MAX_PATTERN-1:0] carry;
    logic [MAX_PATTERN-1:0] cell_en;
    logic [MAX_PATTERN-1:0] sel_top;

    logic in_fire;
    logic work;
    logic inj;
    logic hit_any;
    logic hit_top;
    logic stored_top;
    logic fail;
    logic advance;
    logic do_load;
    logic post_failed;
    logic post_done;
    logic post_bit;
    logic verdict;
    logic skid_full;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_WORDS; k++) begin
                r_word[k] <= '0;
            end
            r_len <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WORD_0: r_word[0] <= i_cfg_data;
                REG_WORD_1: r_word[1] <= i_cfg_data;
                REG_WORD_2: r_word[2] <= i_cfg_data;
                REG_WORD_3: r_word[3] <= i_cfg_data;
                REG_LENGTH: r_len     <= i_cfg_data[PTR_W-1:0];
                default: ;
            endcase
        end
    end

    // Pattern view: flat characters, star positions and the clipped length.
    assign pat_all = {r_word[3], r_word[2], r_word[1], r_word[0]};

    always_comb begin
        for (int j = 0; j < PAT_CHARS; j++) begin
            star_mask[j] = (pat_all[j*CHAR_W +: CHAR_W] == STAR_CHAR);
        end
    end

    assign len_eff = (r_len > PTR_W'(MAX_PATTERN)) ? PTR_W'(MAX_PATTERN) : r_len;

    // Current fragment after skipping stars.
    swm_frag_find u_frag_cur (
        .i_star     (star_mask),
        .i_len      (len_eff),
        .i_start    (r_fs),
        .i_anchored (r_anchored),
        .i_done     (r_done),
        .o_info     (frag_a)
    );

    // Following fragment, used when the current one completes this cycle.
    swm_frag_find u_frag_nxt (
        .i_star     (star_mask),
        .i_len      (len_eff),
        .i_start    (frag_a.stop + PTR_W'(1)),
        .i_anchored (1'b0),
        .i_done     (frag_a.done),
        .o_info     (frag_b)
    );

    // Fragment characters aligned to cell 0.
    assign pat_shift = pat_all >> {frag_a.start, 3'b000};

    // An unanchored fragment may start at any character; an anchored one only at the first.
    assign inj = frag_a.anchored ? (mv == '0) : 1'b1;

    // Chain of shift-and cells, one per fragment position.
    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign carry[g] = inj;
        end else begin : g_body
            assign carry[g] = mv[g-1];
        end
        assign cell_en[g] = PTR_W'(g) < frag_a.flen;
        assign sel_top[g] = (PTR_W'(g) + PTR_W'(1)) == frag_a.flen;

        swm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (cell_ctl),
            .i_pat_char  (pat_shift[g*CHAR_W +: CHAR_W]),
            .i_text_char (i_text_char),
            .i_enable    (cell_en[g]),
            .i_carry     (carry[g]),
            .o_hit       (hit[g]),
            .o_bit       (mv[g])
        );
    end

    assign hit_any    = |hit;
    assign hit_top    = |(hit & sel_top);
    assign stored_top = |(mv & sel_top);

    assign in_fire = i_valid && !o_stall;
    assign work    = i_char_valid && !r_failed && !frag_a.done;

    // Step decision: fail, hand over to the next fragment, or keep matching.
    always_comb begin
        fail    = 1'b0;
        advance = 1'b0;
        do_load = 1'b0;
        if (work) begin
            if (frag_a.flen == '0 || (frag_a.anchored && !hit_any)) begin
                fail = 1'b1;
            end else if (!frag_a.last && hit_top) begin
                advance = 1'b1;
            end else begin
                do_load = 1'b1;
            end
        end
    end

    // Next control state; an end of text returns everything to the start.
    always_comb begin
        n_fs       = r_fs;
        n_anchored = r_anchored;
        n_failed   = r_failed;
        n_done     = r_done;
        cell_ctl   = '0;
        if (in_fire) begin
            if (i_end_of_text) begin
                n_fs           = '0;
                n_anchored     = 1'b1;
                n_failed       = 1'b0;
                n_done         = 1'b0;
                cell_ctl.clear = 1'b1;
            end else if (advance) begin
                n_fs           = frag_b.start;
                n_anchored     = 1'b0;
                n_done         = frag_b.done;
                cell_ctl.clear = 1'b1;
            end else begin
                n_fs           = frag_a.start;
                n_anchored     = frag_a.anchored;
                n_done         = frag_a.done;
                n_failed       = r_failed | fail;
                cell_ctl.clear = fail;
                cell_ctl.load  = do_load;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs       <= '0;
            r_anchored <= 1'b1;
            r_failed   <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_fs       <= n_fs;
            r_anchored <= n_anchored;
            r_failed   <= n_failed;
            r_done     <= n_done;
        end
    end

    // Verdict from the state as it stands after this character.
    assign post_failed = r_failed | fail;
    assign post_done   = advance ? frag_b.done : frag_a.done;
    assign post_info   = advance ? frag_b : frag_a;
    assign post_bit    = do_load ? hit_top : (advance ? 1'b0 : stored_top);

    always_comb begin
        if (post_failed) begin
            verdict = 1'b0;
        end else if (post_done) begin
            verdict = 1'b1;
        end else if (!post_info.last) begin
            verdict = 1'b0;
        end else if (post_info.flen == '0) begin
            verdict = 1'b1;
        end else begin
            verdict = post_bit;
        end
    end

    // Verdict queue toward the output channel.
    swm_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_fire && i_end_of_text),
        .i_data  (verdict),
        .o_full  (skid_full),
        .o_valid (o_valid),
        .o_data  (o_matched),
        .i_stall (i_stall)
    );

    assign o_stall = skid_full;

    // An end-of-text transfer leaves the matcher in its start state.
    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_end_of_text |=>
            (r_fs == '0 && r_anchored && !r_failed && !r_done && mv == '0))
        else $error("state not cleared after end of text");

    // A failed text keeps an empty match chain.
    a_failed_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |-> (mv == '0))
        else $error("match chain not empty after failure");

    // The fragment start never runs past the pattern capacity.
    a_fs_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fs <= PTR_W'(MAX_PATTERN))
        else $error("fragment start beyond pattern capacity");

endmodule
